FILE: sv/ssq_pkg.sv
// Shared types and constants for the single-server queue event stepper.
// No dependencies.
`default_nettype none

package ssq_pkg;

  typedef enum logic [0:0] {
    OP_RESTART = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_ARRIVAL   = 2'd1,
    EV_DEPARTURE = 2'd2
  } event_kind_e;

  // queue commands from the event core; push and pop never coincide
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } q_cmd_t;

  localparam logic [31:0] TARGET_RESET = 32'd1000;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/single_server_queue_event_step.sv
// Top level of the single-server queue event stepper: request register,
// result register, target register. Uses ssq_pkg, ssq_event, ssq_queue.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  request  | in_valid_i / in_stall_o | opcode, interarrival/service samples
//  result   | out_valid_o/out_stall_i | event, time, queue, busy, sums, flags
//  config   | cfg_we_i                | cfg_wdata_i (target_customers)
//
// One request per cycle while the result side is not stalled; an accepted request waits in
// the request register, then goes through the event logic into the result register.
// The event loop closes through the state registers and the head-of-queue register,
// which is loaded ahead of time from the queue memory.
// Reset is asynchronous; no clearing pass is needed after it.
// A stalled result holds the request register; one result and one request wait.
`default_nettype none

module single_server_queue_event_step #(
  parameter int QUEUE_DEPTH = 128,
  parameter int TIME_BITS   = 48,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire  [31:0]           cfg_wdata_i,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [0:0]            opcode_i,
  input  wire  [31:0]           interarrival_sample_i,
  input  wire  [31:0]           service_sample_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [1:0]            event_kind_o,
  output logic [TIME_BITS-1:0]  current_time_o,
  output logic [CntW-1:0]       waiting_count_o,
  output logic                  server_busy_o,
  output logic [31:0]           served_count_o,
  output logic [63:0]           delay_sum_o,
  output logic [63:0]           queue_area_o,
  output logic [63:0]           busy_area_o,
  output logic                  run_done_o,
  output logic                  overflow_error_o
);
  import ssq_pkg::*;

  logic [31:0]          target_q;
  logic                 req_vld_q, out_vld_q;
  opcode_e              op_q;
  logic [31:0]          ia_q, sv_q;
  logic                 res_free, fire, accept;

  q_cmd_t               q_cmd;
  logic [TIME_BITS-1:0] q_wdata, q_head;
  logic [CntW-1:0]      q_count;

  event_kind_e          kind_c;
  logic [TIME_BITS-1:0] time_c;
  logic [CntW-1:0]      count_c;
  logic                 busy_c, done_c, halt_c;
  logic [31:0]          served_c;
  logic [63:0]          delay_c, qarea_c, barea_c;

  event_kind_e          kind_q;
  logic [TIME_BITS-1:0] time_q;
  logic [CntW-1:0]      count_q;
  logic                 busy_q, done_q, halt_q;
  logic [31:0]          served_q;
  logic [63:0]          delay_q, qarea_q, barea_q;

  assign res_free   = !out_vld_q || !out_stall_i;
  assign fire       = req_vld_q && res_free;
  assign in_stall_o = req_vld_q && !res_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        req_vld_q <= 1'b1;
      end else if (fire) begin
        req_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= opcode_e'(opcode_i);
      ia_q <= interarrival_sample_i;
      sv_q <= service_sample_i;
    end
  end

  ssq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_cmd),
    .wdata_i    (q_wdata),
    .count_o    (q_count),
    .head_val_o (q_head)
  );

  ssq_event #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_event (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .opcode_i  (op_q),
    .ia_i      (ia_q),
    .sv_i      (sv_q),
    .target_i  (target_q),
    .q_count_i (q_count),
    .q_head_i  (q_head),
    .q_cmd_o   (q_cmd),
    .q_wdata_o (q_wdata),
    .kind_o    (kind_c),
    .time_o    (time_c),
    .count_o   (count_c),
    .busy_o    (busy_c),
    .served_o  (served_c),
    .delay_o   (delay_c),
    .qarea_o   (qarea_c),
    .barea_o   (barea_c),
    .done_o    (done_c),
    .halted_o  (halt_c)
  );

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q   <= kind_c;
      time_q   <= time_c;
      count_q  <= count_c;
      busy_q   <= busy_c;
      served_q <= served_c;
      delay_q  <= delay_c;
      qarea_q  <= qarea_c;
      barea_q  <= barea_c;
      done_q   <= done_c;
      halt_q   <= halt_c;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign event_kind_o     = kind_q;
  assign current_time_o   = time_q;
  assign waiting_count_o  = count_q;
  assign server_busy_o    = busy_q;
  assign served_count_o   = served_q;
  assign delay_sum_o      = delay_q;
  assign queue_area_o     = qarea_q;
  assign busy_area_o      = barea_q;
  assign run_done_o       = done_q;
  assign overflow_error_o = halt_q;

endmodule

`default_nettype wire

FILE: sv/ssq_queue.sv
// Arrival-time queue: circular buffer in a memory, with the head entry kept
// in a register so a departure sees it without a read cycle. Uses ssq_pkg.
`default_nettype none

module ssq_queue #(
  parameter int QUEUE_DEPTH = 128,
  parameter int TIME_BITS   = 48,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1),
  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  ssq_pkg::q_cmd_t       cmd_i,
  input  wire  [TIME_BITS-1:0]  wdata_i,
  output logic [CntW-1:0]       count_o,
  output logic [TIME_BITS-1:0]  head_val_o
);
  import ssq_pkg::*;

  logic [TIME_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PtrW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [TIME_BITS-1:0] head_val_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (cmd_i.push) begin
      tail_d  = next_ptr(tail_q);
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      head_d  = next_ptr(head_q);
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[tail_q] <= wdata_i;
    end
  end

  // registered read of the next head, bypassing a write to that entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (tail_q == head_d)) begin
      head_val_q <= wdata_i;
    end else begin
      head_val_q <= mem[head_d];
    end
  end

  assign count_o    = count_q;
  assign head_val_o = head_val_q;

endmodule

`default_nettype wire

FILE: sv/ssq_event.sv
// Event core: scheduling state, accumulators and the one-event update.
// Drives ssq_queue commands; uses ssq_pkg.
`default_nettype none

module ssq_event #(
  parameter int QUEUE_DEPTH = 128,
  parameter int TIME_BITS   = 48,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   fire_i,
  input  ssq_pkg::opcode_e      opcode_i,
  input  wire  [31:0]           ia_i,
  input  wire  [31:0]           sv_i,
  input  wire  [31:0]           target_i,
  input  wire  [CntW-1:0]       q_count_i,
  input  wire  [TIME_BITS-1:0]  q_head_i,
  output ssq_pkg::q_cmd_t       q_cmd_o,
  output logic [TIME_BITS-1:0]  q_wdata_o,
  output ssq_pkg::event_kind_e  kind_o,
  output logic [TIME_BITS-1:0]  time_o,
  output logic [CntW-1:0]       count_o,
  output logic                  busy_o,
  output logic [31:0]           served_o,
  output logic [63:0]           delay_o,
  output logic [63:0]           qarea_o,
  output logic [63:0]           barea_o,
  output logic                  done_o,
  output logic                  halted_o
);
  import ssq_pkg::*;

  localparam int SumW  = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam int ProdW = CntW + TIME_BITS;
  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  logic [TIME_BITS-1:0] now_q, now_d, narr_q, narr_d, ndep_q, ndep_d;
  logic                 dpend_q, dpend_d, busy_q, busy_d, halt_q, halt_d;
  logic [31:0]          served_q, served_d;
  logic [63:0]          delay_q, delay_d, qarea_q, qarea_d, barea_q, barea_d;
  logic [CntW-1:0]      count_d;

  logic                 is_dep;
  logic [TIME_BITS-1:0] t, dt, wait_t;
  logic [ProdW-1:0]     prod;
  logic                 q_full;
  q_cmd_t               cmd;
  event_kind_e          kind;

  function automatic logic [TIME_BITS-1:0] schedule(input logic [TIME_BITS-1:0] base,
                                                    input logic [31:0] draw);
    logic [SumW-1:0] s;
    s = SumW'(base) + SumW'(draw);
    return (s > SumW'(TimeMax)) ? TimeMax : TIME_BITS'(s);
  endfunction

  assign is_dep = dpend_q && (ndep_q < narr_q);
  assign t      = is_dep ? ndep_q : narr_q;
  assign dt     = (t > now_q) ? t - now_q : '0;
  assign wait_t = (t > q_head_i) ? t - q_head_i : '0;
  assign prod   = ProdW'(q_count_i) * ProdW'(dt);
  assign q_full = (q_count_i >= CntW'(QUEUE_DEPTH));

  always_comb begin
    now_d    = now_q;
    narr_d   = narr_q;
    ndep_d   = ndep_q;
    dpend_d  = dpend_q;
    busy_d   = busy_q;
    halt_d   = halt_q;
    served_d = served_q;
    delay_d  = delay_q;
    qarea_d  = qarea_q;
    barea_d  = barea_q;
    count_d  = q_count_i;
    cmd      = '0;
    kind     = EV_NONE;
    if (opcode_i == OP_RESTART) begin
      cmd.clear = 1'b1;
      now_d     = '0;
      narr_d    = schedule('0, ia_i);
      ndep_d    = '0;
      dpend_d   = 1'b0;
      busy_d    = 1'b0;
      halt_d    = 1'b0;
      served_d  = '0;
      delay_d   = '0;
      qarea_d   = '0;
      barea_d   = '0;
      count_d   = '0;
    end else if (!halt_q) begin
      qarea_d = sat_add64(qarea_q, 64'(prod));
      if (busy_q) begin
        barea_d = sat_add64(barea_q, 64'(dt));
      end
      now_d = t;
      if (!is_dep) begin
        kind   = EV_ARRIVAL;
        narr_d = schedule(t, ia_i);
        if (busy_q) begin
          if (q_full) begin
            halt_d = 1'b1;
          end else begin
            cmd.push = 1'b1;
            count_d  = q_count_i + CntW'(1);
          end
        end else begin
          if (served_q != '1) served_d = served_q + 32'd1;
          busy_d  = 1'b1;
          ndep_d  = schedule(t, sv_i);
          dpend_d = 1'b1;
        end
      end else begin
        kind = EV_DEPARTURE;
        if (q_count_i == '0) begin
          busy_d  = 1'b0;
          dpend_d = 1'b0;
        end else begin
          delay_d = sat_add64(delay_q, 64'(wait_t));
          if (served_q != '1) served_d = served_q + 32'd1;
          ndep_d  = schedule(t, sv_i);
          cmd.pop = 1'b1;
          count_d = q_count_i - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q    <= '0;
      narr_q   <= '0;
      ndep_q   <= '0;
      dpend_q  <= 1'b0;
      busy_q   <= 1'b0;
      halt_q   <= 1'b0;
      served_q <= '0;
      delay_q  <= '0;
      qarea_q  <= '0;
      barea_q  <= '0;
    end else if (fire_i) begin
      now_q    <= now_d;
      narr_q   <= narr_d;
      ndep_q   <= ndep_d;
      dpend_q  <= dpend_d;
      busy_q   <= busy_d;
      halt_q   <= halt_d;
      served_q <= served_d;
      delay_q  <= delay_d;
      qarea_q  <= qarea_d;
      barea_q  <= barea_d;
    end
  end

  assign q_cmd_o   = fire_i ? cmd : '0;
  assign q_wdata_o = t;
  assign kind_o    = kind;
  assign time_o    = now_d;
  assign count_o   = count_d;
  assign busy_o    = busy_d;
  assign served_o  = served_d;
  assign delay_o   = delay_d;
  assign qarea_o   = qarea_d;
  assign barea_o   = barea_d;
  assign done_o    = (served_d >= target_i);
  assign halted_o  = halt_d;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for single_server_queue_event_step: randomized and directed
// requests with an in-bench predictor of the queue event model, valid/stall on both sides.
// Depends on ssq_pkg and the top level of the block.
`timescale 1ns / 1ps

module tb_top;
  import ssq_pkg::*;

  localparam int          QDEPTH      = 128;
  localparam logic [47:0] TMAX        = {48{1'b1}};
  localparam int          CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    opcode_e     op;
    logic [31:0] ia;
    logic [31:0] sv;
  } ssq_req_t;

  typedef struct packed {
    event_kind_e kind;
    logic [47:0] now;
    logic [7:0]  waiting;
    logic        busy;
    logic [31:0] served;
    logic [63:0] delay_sum;
    logic [63:0] queue_area;
    logic [63:0] busy_area;
    logic        done;
    logic        ovf;
  } ssq_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [0:0]  opcode_i = '0;
  logic [31:0] interarrival_sample_i = '0;
  logic [31:0] service_sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  event_kind_o;
  logic [47:0] current_time_o;
  logic [7:0]  waiting_count_o;
  logic        server_busy_o;
  logic [31:0] served_count_o;
  logic [63:0] delay_sum_o;
  logic [63:0] queue_area_o;
  logic [63:0] busy_area_o;
  logic        run_done_o;
  logic        overflow_error_o;

  single_server_queue_event_step dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .opcode_i              (opcode_i),
    .interarrival_sample_i (interarrival_sample_i),
    .service_sample_i      (service_sample_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .event_kind_o          (event_kind_o),
    .current_time_o        (current_time_o),
    .waiting_count_o       (waiting_count_o),
    .server_busy_o         (server_busy_o),
    .served_count_o        (served_count_o),
    .delay_sum_o           (delay_sum_o),
    .queue_area_o          (queue_area_o),
    .busy_area_o           (busy_area_o),
    .run_done_o            (run_done_o),
    .overflow_error_o      (overflow_error_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] target_cfg;
  logic [47:0] sim_clock, arr_due, dep_due;
  logic        dep_armed, srv_busy, stuck;
  logic [47:0] wait_times[$];
  logic [31:0] n_served;
  logic [63:0] delay_acc, qlen_acc, busy_acc;

  ssq_req_t    reqs_waiting[$];
  ssq_req_t    req_on_bus;
  ssq_result_t results_due[$];

  int send_gap_pct = 35;
  int stall_pct = 46;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_left = 0;
  int n_cycles = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_arrivals = 0;
  int n_departures = 0;
  int n_halted = 0;
  int n_done = 0;
  int n_time_sat = 0;

  function automatic logic [63:0] add_clamp64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [47:0] sched_time(logic [47:0] now, logic [31:0] draw);
    logic [48:0] s;
    s = {1'b0, now} + {17'd0, draw};
    return s[48] ? TMAX : s[47:0];
  endfunction

  function automatic void clear_queue_model();
    sim_clock = '0;
    arr_due   = '0;
    dep_due   = '0;
    dep_armed = 1'b0;
    srv_busy  = 1'b0;
    stuck     = 1'b0;
    wait_times.delete();
    n_served  = '0;
    delay_acc = '0;
    qlen_acc  = '0;
    busy_acc  = '0;
  endfunction

  function automatic void log_served(logic [47:0] d);
    delay_acc = add_clamp64(delay_acc, {16'd0, d});
    if (n_served != {32{1'b1}}) n_served++;
  endfunction

  function automatic ssq_result_t advance_queue_model(ssq_req_t r);
    ssq_result_t res;
    event_kind_e kind;
    logic        take_dep;
    logic [47:0] t_evt, dt, t_in;
    kind = EV_NONE;
    if (r.op == OP_RESTART) begin
      clear_queue_model();
      arr_due = sched_time(48'd0, r.ia);
    end else if (!stuck) begin
      take_dep = dep_armed && (dep_due < arr_due);
      t_evt = take_dep ? dep_due : arr_due;
      dt = (t_evt > sim_clock) ? t_evt - sim_clock : 48'd0;
      qlen_acc = add_clamp64(qlen_acc, 64'(wait_times.size()) * {16'd0, dt});
      if (srv_busy) busy_acc = add_clamp64(busy_acc, {16'd0, dt});
      sim_clock = t_evt;
      if (!take_dep) begin
        kind = EV_ARRIVAL;
        arr_due = sched_time(t_evt, r.ia);
        if (srv_busy) begin
          if (wait_times.size() >= QDEPTH) stuck = 1'b1;
          else wait_times.push_back(t_evt);
        end else begin
          log_served(48'd0);
          srv_busy  = 1'b1;
          dep_due   = sched_time(t_evt, r.sv);
          dep_armed = 1'b1;
        end
      end else begin
        kind = EV_DEPARTURE;
        if (wait_times.size() == 0) begin
          srv_busy  = 1'b0;
          dep_armed = 1'b0;
        end else begin
          t_in = wait_times.pop_front();
          log_served((t_evt > t_in) ? t_evt - t_in : 48'd0);
          dep_due = sched_time(t_evt, r.sv);
        end
      end
    end
    res.kind       = kind;
    res.now        = sim_clock;
    res.waiting    = 8'(wait_times.size());
    res.busy       = srv_busy;
    res.served     = n_served;
    res.delay_sum  = delay_acc;
    res.queue_area = qlen_acc;
    res.busy_area  = busy_acc;
    res.done       = (n_served >= target_cfg);
    res.ovf        = stuck;
    return res;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        results_due.push_back(advance_queue_model(req_on_bus));
        n_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (reqs_waiting.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          req_on_bus = reqs_waiting.pop_front();
          in_valid_i            <= 1'b1;
          opcode_i              <= req_on_bus.op;
          interarrival_sample_i <= req_on_bus.ia;
          service_sample_i      <= req_on_bus.sv;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= 30)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // result monitor and receiver stall
  always @(posedge clk_i) begin
    ssq_result_t exp;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          n_errors++;
          $display("%0t: result with no request outstanding, actual kind %0d time %0h",
                   $time, event_kind_o, current_time_o);
        end else begin
          exp = results_due.pop_front();
          n_checked++;
          check_field("event_kind", 64'(exp.kind), 64'(event_kind_o));
          check_field("current_time", 64'(exp.now), 64'(current_time_o));
          check_field("waiting_count", 64'(exp.waiting), 64'(waiting_count_o));
          check_field("server_busy", 64'(exp.busy), 64'(server_busy_o));
          check_field("served_count", 64'(exp.served), 64'(served_count_o));
          check_field("delay_sum", exp.delay_sum, delay_sum_o);
          check_field("queue_area", exp.queue_area, queue_area_o);
          check_field("busy_area", exp.busy_area, busy_area_o);
          check_field("run_done", 64'(exp.done), 64'(run_done_o));
          check_field("overflow_error", 64'(exp.ovf), 64'(overflow_error_o));
          if (exp.kind == EV_ARRIVAL) n_arrivals++;
          if (exp.kind == EV_DEPARTURE) n_departures++;
          if (exp.ovf) n_halted++;
          if (exp.done) n_done++;
          if (exp.now == TMAX) n_time_sat++;
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               results_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_req(input opcode_e op, input logic [31:0] ia, input logic [31:0] sv);
    ssq_req_t r;
    r.op = op;
    r.ia = ia;
    r.sv = sv;
    reqs_waiting.push_back(r);
  endtask

  function automatic logic [31:0] rand_draw(int bits);
    if (bits <= 0) return 32'd0;
    if (bits >= 32) return $urandom();
    return $urandom() >> (32 - bits);
  endfunction

  // runs of advances after a restart, with some noise and runs left unrestarted
  task automatic random_runs(input int n_items);
    int pushed, run_len, ia_bits, sv_bits;
    pushed = 0;
    while (pushed < n_items) begin
      run_len = $urandom_range(5, 60);
      ia_bits = $urandom_range(2, 32);
      sv_bits = ia_bits + $urandom_range(0, 4) - 2;
      if ($urandom_range(9) != 0) begin
        queue_req(OP_RESTART, rand_draw(ia_bits), $urandom());
        pushed++;
      end
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(99) < 8)
          queue_req(opcode_e'($urandom_range(1)), $urandom(), $urandom());
        else
          queue_req(OP_ADVANCE, rand_draw(ia_bits + $urandom_range(0, 2) - 1),
                    rand_draw(sv_bits + $urandom_range(0, 2) - 1));
        pushed++;
      end
    end
  endtask

  // fast arrivals against a very long service fill the queue until it overflows
  task automatic overflow_run();
    queue_req(OP_RESTART, $urandom_range(0, 200), $urandom());
    queue_req(OP_ADVANCE, $urandom_range(1, 200), 32'hFFFF_FFFF);
    for (int i = 0; i < 133; i++)
      queue_req(OP_ADVANCE, $urandom_range(0, 200), $urandom());
  endtask

  task automatic wait_idle();
    while (reqs_waiting.size() != 0 || in_valid_i || results_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_target(input logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    target_cfg = v;
  endtask

  initial begin
    clear_queue_model();
    target_cfg = TARGET_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: advance out of reset, empty server, ties, extreme draws
    queue_req(OP_ADVANCE, 32'd5, 32'd3);
    queue_req(OP_ADVANCE, 32'd7, 32'd2);
    queue_req(OP_ADVANCE, 32'd1, 32'd1);
    queue_req(OP_RESTART, 32'd0, 32'hFFFF_FFFF);
    queue_req(OP_ADVANCE, 32'd0, 32'd0);
    queue_req(OP_ADVANCE, 32'd0, 32'd0);
    queue_req(OP_ADVANCE, 32'd10, 32'd0);
    queue_req(OP_ADVANCE, 32'd4, 32'd6);
    queue_req(OP_ADVANCE, 32'd4, 32'd6);
    queue_req(OP_ADVANCE, 32'd4, 32'd6);
    queue_req(OP_ADVANCE, 32'd4, 32'd6);
    queue_req(OP_RESTART, 32'hFFFF_FFFF, 32'd0);
    queue_req(OP_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(OP_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(OP_ADVANCE, 32'h0001_0000, 32'hFFFF_FFFF);
    queue_req(OP_ADVANCE, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_req(OP_ADVANCE, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_req(OP_ADVANCE, 32'hFFFF_FFFF, 32'd0);
    queue_req(OP_RESTART, 32'h8000_0000, 32'h8000_0000);
    queue_req(OP_ADVANCE, 32'd1, 32'd1);
    random_runs(150);
    long_hold_req = 1'b1;
    random_runs(80);
    wait_idle();
    random_runs(80);
    overflow_run();
    random_runs(20);
    wait_idle();

    set_target(32'd1);
    send_gap_pct = 46;
    stall_pct = 35;
    random_runs(180);
    overflow_run();
    random_runs(40);
    wait_idle();

    set_target(32'hFFFF_FFFF);
    send_gap_pct = 0;
    stall_pct = 0;
    random_runs(140);
    wait_idle();

    set_target($urandom_range(2, 60));
    random_runs(50);
    random_runs(20);
    wait_idle();

    $display("%0d requests, %0d results checked: %0d arrivals, %0d departures",
             n_accepted, n_checked, n_arrivals, n_departures);
    $display("%0d halted by overflow, %0d with run done, %0d at saturated time, %0d errors",
             n_halted, n_done, n_time_sat, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ssq_pkg.sv
sv/ssq_queue.sv
sv/ssq_event.sv
sv/single_server_queue_event_step.sv
tb/tb_top.sv
